// ===== rtl/tsw_pkg.sv =====
package tsw_pkg;

    // Store and arithmetic sizes
    localparam int MAX_TEXELS  = 65536;
    localparam int WEIGHT_BITS = 8;
    localparam int TEX_ADDR_W  = $clog2(MAX_TEXELS);

    localparam int SIZE_W   = 9;                    // width / height register
    localparam int COORD_W  = 8;                    // texel column or row
    localparam int FRAC_W   = 16;                   // wrapped coordinate fraction
    localparam int FETCH_W  = 17;                   // x + y*width before range check
    localparam int INDEX_W  = 16;                   // load address field
    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 3;
    localparam int TEXEL_W  = CHAN_W * NUM_CHAN;
    localparam int OUT_W    = 16;
    localparam int NUM_TAPS = 4;

    localparam int WT_W   = WEIGHT_BITS + 1;        // W - dx
    localparam int BW_W   = 2 * WEIGHT_BITS + 1;    // one bilinear weight
    localparam int PROD_W = CHAN_W + BW_W;          // channel times weight
    localparam int SUM_W  = PROD_W + 2;             // sum of four taps
    localparam int RND_W  = SUM_W + 8;              // sum scaled to 8.8

    localparam int PIPE_STAGES = 6;

    localparam logic [WT_W-1:0]   W_ONE     = WT_W'(1) << WEIGHT_BITS;
    localparam logic [RND_W-1:0]  RND_HALF  = RND_W'(1) << (2 * WEIGHT_BITS - 1);
    localparam logic [SIZE_W-1:0] SIZE_MAX  = SIZE_W'(256);
    localparam logic [SIZE_W-1:0] SIZE_MIN  = SIZE_W'(1);
    localparam logic [OUT_W-1:0]  CHAN_ONE  = OUT_W'(16'hFF00);

    // Tap order in the texel store copies
    localparam int TAP_BL = 0;
    localparam int TAP_BR = 1;
    localparam int TAP_TL = 2;
    localparam int TAP_TR = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_FILTER = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd;

    typedef enum logic {
        FILT_NEAREST  = 1'b0,
        FILT_BILINEAR = 1'b1
    } t_filter;

    // Per-stage load enables of the pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } t_pipe_en;

    // Texel store write request from the address stage
    typedef struct packed {
        logic                  req;
        logic [TEX_ADDR_W-1:0] addr;
        logic [TEXEL_W-1:0]    data;
    } t_store_wr;

    // Zero and one sizes act as one, large sizes saturate
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        r = s;
        if (s == '0) begin
            r = SIZE_MIN;
        end else if (s > SIZE_MAX) begin
            r = SIZE_MAX;
        end
        return r;
    endfunction

    function automatic logic in_store(input logic [FETCH_W-1:0] a);
        return (32'(a) < MAX_TEXELS);
    endfunction

    function automatic logic [TEX_ADDR_W-1:0] to_store_addr(input logic [FETCH_W-1:0] a);
        logic [TEX_ADDR_W+FETCH_W-1:0] ext;
        ext = {{TEX_ADDR_W{1'b0}}, a};
        return ext[TEX_ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/tsw_ram.sv =====
module tsw_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, hold while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tsw_front.sv =====
module tsw_front import tsw_pkg::*; (
    input  logic                              i_clk,
    input  t_pipe_en                          i_en,
    input  logic [SIZE_W-1:0]                 i_width,
    input  logic [SIZE_W-1:0]                 i_height,
    input  t_filter                           i_mode,
    input  logic                              i_cmd,
    input  logic [INDEX_W-1:0]                i_texel_index,
    input  logic [TEXEL_W-1:0]                i_texel,
    input  logic [FRAC_W-1:0]                 i_u_frac,
    input  logic [FRAC_W-1:0]                 i_v_frac,
    output t_cmd                              o_s3_cmd,
    output t_store_wr                         o_wr,
    output logic [NUM_TAPS-1:0][TEX_ADDR_W-1:0] o_tap_addr,
    output logic [NUM_TAPS-1:0]               o_tap_oob,
    output logic [NUM_TAPS-1:0][BW_W-1:0]     o_tap_wt
);

    // Stage 1: captured item
    t_cmd                r_s1_cmd;
    logic [INDEX_W-1:0]  r_s1_index;
    logic [TEXEL_W-1:0]  r_s1_texel;
    logic [FRAC_W-1:0]   r_s1_u;
    logic [FRAC_W-1:0]   r_s1_v;

    // Stage 2: texel position and weights
    t_cmd                   r_s2_cmd;
    logic [INDEX_W-1:0]     r_s2_index;
    logic [TEXEL_W-1:0]     r_s2_texel;
    logic [COORD_W-1:0]     r_s2_x0, r_s2_x1, r_s2_y0, r_s2_y1;
    logic [WEIGHT_BITS-1:0] r_s2_dx, r_s2_dy;

    // Stage 3: store addresses and blend weights
    t_cmd                              r_s3_cmd;
    t_store_wr                         r_s3_wr;
    logic [NUM_TAPS-1:0][FETCH_W-1:0]  r_s3_addr;
    logic [NUM_TAPS-1:0][BW_W-1:0]     r_s3_wt;

    logic [FRAC_W+SIZE_W-1:0]  n_pu, n_pv;
    logic [COORD_W-1:0]        n_x0, n_y0, n_x1, n_y1;
    logic [SIZE_W-1:0]         n_x0p1, n_y0p1;
    logic [WEIGHT_BITS-1:0]    n_dx, n_dy;
    logic [FETCH_W-1:0]        n_row0, n_row1;
    logic [WT_W-1:0]           n_nx, n_ny;
    logic [NUM_TAPS-1:0][FETCH_W-1:0] n_addr;
    logic [NUM_TAPS-1:0][BW_W-1:0]    n_wt;

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_s1_cmd   <= t_cmd'(i_cmd);
            r_s1_index <= i_texel_index;
            r_s1_texel <= i_texel;
            r_s1_u     <= i_u_frac;
            r_s1_v     <= i_v_frac;
        end
    end

    // Scale the wrapped fractions by the texture size
    always_comb begin
        n_pu   = (FRAC_W+SIZE_W)'(r_s1_u) * (FRAC_W+SIZE_W)'(i_width);
        n_pv   = (FRAC_W+SIZE_W)'(r_s1_v) * (FRAC_W+SIZE_W)'(i_height);
        n_x0   = n_pu[FRAC_W +: COORD_W];
        n_y0   = n_pv[FRAC_W +: COORD_W];
        n_dx   = n_pu[FRAC_W-1 -: WEIGHT_BITS];
        n_dy   = n_pv[FRAC_W-1 -: WEIGHT_BITS];
        // nearest mode is the blend with all weight on the base texel
        if (i_mode == FILT_NEAREST) begin
            n_dx = '0;
            n_dy = '0;
        end
        // right and top neighbours wrap to zero at the edge
        n_x0p1 = SIZE_W'(n_x0) + SIZE_W'(1);
        n_y0p1 = SIZE_W'(n_y0) + SIZE_W'(1);
        n_x1   = (n_x0p1 == i_width)  ? '0 : n_x0p1[COORD_W-1:0];
        n_y1   = (n_y0p1 == i_height) ? '0 : n_y0p1[COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_s2_cmd   <= r_s1_cmd;
            r_s2_index <= r_s1_index;
            r_s2_texel <= r_s1_texel;
            r_s2_x0    <= n_x0;
            r_s2_x1    <= n_x1;
            r_s2_y0    <= n_y0;
            r_s2_y1    <= n_y1;
            r_s2_dx    <= n_dx;
            r_s2_dy    <= n_dy;
        end
    end

    // Form the four tap addresses and the four bilinear weights
    always_comb begin
        n_row0 = FETCH_W'(r_s2_y0) * FETCH_W'(i_width);
        n_row1 = FETCH_W'(r_s2_y1) * FETCH_W'(i_width);
        n_addr[TAP_BL] = n_row0 + FETCH_W'(r_s2_x0);
        n_addr[TAP_BR] = n_row0 + FETCH_W'(r_s2_x1);
        n_addr[TAP_TL] = n_row1 + FETCH_W'(r_s2_x0);
        n_addr[TAP_TR] = n_row1 + FETCH_W'(r_s2_x1);
        n_nx = W_ONE - WT_W'(r_s2_dx);
        n_ny = W_ONE - WT_W'(r_s2_dy);
        n_wt[TAP_BL] = BW_W'(n_nx) * BW_W'(n_ny);
        n_wt[TAP_BR] = BW_W'(r_s2_dx) * BW_W'(n_ny);
        n_wt[TAP_TL] = BW_W'(n_nx) * BW_W'(r_s2_dy);
        n_wt[TAP_TR] = BW_W'(r_s2_dx) * BW_W'(r_s2_dy);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_s3_cmd     <= r_s2_cmd;
            r_s3_wr.req  <= (r_s2_cmd == CMD_LOAD) && in_store({1'b0, r_s2_index});
            r_s3_wr.addr <= to_store_addr({1'b0, r_s2_index});
            r_s3_wr.data <= r_s2_texel;
            r_s3_addr    <= n_addr;
            r_s3_wt      <= n_wt;
        end
    end

    // Drive store ports from stage 3
    always_comb begin
        for (int t = 0; t < NUM_TAPS; t++) begin
            o_tap_addr[t] = to_store_addr(r_s3_addr[t]);
            o_tap_oob[t]  = !in_store(r_s3_addr[t]);
        end
    end

    assign o_s3_cmd = r_s3_cmd;
    assign o_wr     = r_s3_wr;
    assign o_tap_wt = r_s3_wt;

endmodule

// ===== rtl/tsw_blend.sv =====
module tsw_blend import tsw_pkg::*; (
    input  logic                              i_clk,
    input  t_pipe_en                          i_en,
    input  logic [NUM_TAPS-1:0]               i_tap_oob,
    input  logic [NUM_TAPS-1:0][BW_W-1:0]     i_tap_wt,
    input  logic [NUM_TAPS-1:0][TEXEL_W-1:0]  i_tap_texel,
    output logic [NUM_CHAN-1:0][OUT_W-1:0]    o_chan
);

    // Stage 4 side data, aligned with the store read data
    logic [NUM_TAPS-1:0]           r_s4_oob;
    logic [NUM_TAPS-1:0][BW_W-1:0] r_s4_wt;

    // Stage 5 products, stage 6 result
    logic [NUM_CHAN-1:0][NUM_TAPS-1:0][PROD_W-1:0] r_s5_prod;
    logic [NUM_CHAN-1:0][OUT_W-1:0]                r_s6_chan;

    logic [NUM_CHAN-1:0][NUM_TAPS-1:0][PROD_W-1:0] n_prod;
    logic [NUM_CHAN-1:0][OUT_W-1:0]                n_chan;
    logic [TEXEL_W-1:0]                            n_texel;
    logic [SUM_W-1:0]                              n_sum;
    logic [RND_W-1:0]                              n_rnd;

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_s4_oob <= i_tap_oob;
            r_s4_wt  <= i_tap_wt;
        end
    end

    // Weight each channel of each tap; an address past the store or a tap
    // with no weight reads as zero
    always_comb begin
        for (int t = 0; t < NUM_TAPS; t++) begin
            n_texel = (r_s4_oob[t] || (r_s4_wt[t] == '0)) ? '0 : i_tap_texel[t];
            for (int c = 0; c < NUM_CHAN; c++) begin
                n_prod[c][t] = PROD_W'(n_texel[c*CHAN_W +: CHAN_W]) * PROD_W'(r_s4_wt[t]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_s5_prod <= n_prod;
        end
    end

    // Sum the taps, scale to 8.8 and round half up
    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            n_sum = SUM_W'(r_s5_prod[c][TAP_BL]) + SUM_W'(r_s5_prod[c][TAP_BR])
                  + SUM_W'(r_s5_prod[c][TAP_TL]) + SUM_W'(r_s5_prod[c][TAP_TR]);
            n_rnd = (RND_W'(n_sum) << 8) + RND_HALF;
            n_chan[c] = n_rnd[2*WEIGHT_BITS +: OUT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s6) begin
            r_s6_chan <= n_chan;
        end
    end

    assign o_chan = r_s6_chan;

endmodule

// ===== rtl/texture_sampler_wrap_bilinear_unit.sv =====
// Texture sampler with repeat addressing and nearest or bilinear filtering. Load items
// (cmd 0) write one RGB texel into the store and give no result; sample items (cmd 1)
// give one result of three 8.8 channels. The unit is a six-stage pipeline that takes
// one item every cycle while the output is not stalled: capture, fraction scaling,
// address and weight forming, store read, channel products, and the rounded sum in the
// output register. The store is kept as four identical copies, one read port per filter
// tap, so the four neighbour texels are read in the same cycle; every load writes all
// four copies. A load takes effect in program order for all samples that follow it.
// Texels never loaded read as undefined. The user must write configuration only while
// no item is in flight; the unit itself does not enforce it.
module texture_sampler_wrap_bilinear_unit import tsw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_cmd,
    input  logic [INDEX_W-1:0]    i_texel_index,
    input  logic [CHAN_W-1:0]     i_red_in,
    input  logic [CHAN_W-1:0]     i_green_in,
    input  logic [CHAN_W-1:0]     i_blue_in,
    input  logic signed [31:0]    i_u_coord,
    input  logic signed [31:0]    i_v_coord,
    // result items
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [OUT_W-1:0]      o_red_out,
    output logic [OUT_W-1:0]      o_green_out,
    output logic [OUT_W-1:0]      o_blue_out
);

    logic [SIZE_W-1:0] r_cfg_width;
    logic [SIZE_W-1:0] r_cfg_height;
    t_filter           r_cfg_mode;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    t_pipe_en                           w_en;
    t_cmd                               w_s3_cmd;
    t_store_wr                          w_wr;
    logic [NUM_TAPS-1:0][TEX_ADDR_W-1:0] w_tap_addr;
    logic [NUM_TAPS-1:0]                w_tap_oob;
    logic [NUM_TAPS-1:0][BW_W-1:0]      w_tap_wt;
    logic [NUM_TAPS-1:0][TEXEL_W-1:0]   w_tap_texel;
    logic [NUM_CHAN-1:0][OUT_W-1:0]     w_chan;
    logic                               w_store_we;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= SIZE_MAX;
            r_cfg_height <= SIZE_MAX;
            r_cfg_mode   <= FILT_BILINEAR;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_cfg_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_HEIGHT: r_cfg_height <= i_cfg_data[SIZE_W-1:0];
                CFG_FILTER: r_cfg_mode   <= t_filter'(i_cfg_data[0]);
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or its content moves on
    always_comb begin
        w_en.s6 = !r_v6 || !i_stall;
        w_en.s5 = !r_v5 || w_en.s6;
        w_en.s4 = !r_v4 || w_en.s5;
        w_en.s3 = !r_v3 || w_en.s4;
        w_en.s2 = !r_v2 || w_en.s3;
        w_en.s1 = !r_v1 || w_en.s2;
    end

    // Advance valid bits; loads drop out once they have written the store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_en.s1) r_v1 <= i_valid;
            if (w_en.s2) r_v2 <= r_v1;
            if (w_en.s3) r_v3 <= r_v2;
            if (w_en.s4) r_v4 <= r_v3 && (w_s3_cmd == CMD_SAMPLE);
            if (w_en.s5) r_v5 <= r_v4;
            if (w_en.s6) r_v6 <= r_v5;
        end
    end

    tsw_front u_front (
        .i_clk         (i_clk),
        .i_en          (w_en),
        .i_width       (clamp_size(r_cfg_width)),
        .i_height      (clamp_size(r_cfg_height)),
        .i_mode        (r_cfg_mode),
        .i_cmd         (i_cmd),
        .i_texel_index (i_texel_index),
        .i_texel       ({i_blue_in, i_green_in, i_red_in}),
        .i_u_frac      (i_u_coord[FRAC_W-1:0]),
        .i_v_frac      (i_v_coord[FRAC_W-1:0]),
        .o_s3_cmd      (w_s3_cmd),
        .o_wr          (w_wr),
        .o_tap_addr    (w_tap_addr),
        .o_tap_oob     (w_tap_oob),
        .o_tap_wt      (w_tap_wt)
    );

    // Write the store as the load leaves stage 3, the stage where samples read it
    assign w_store_we = r_v3 && w_en.s4 && w_wr.req;

    for (genvar t = 0; t < NUM_TAPS; t++) begin : g_store
        tsw_ram #(
            .DATA_W (TEXEL_W),
            .DEPTH  (MAX_TEXELS)
        ) u_store (
            .i_clk   (i_clk),
            .i_we    (w_store_we),
            .i_waddr (w_wr.addr),
            .i_wdata (w_wr.data),
            .i_re    (w_en.s4),
            .i_raddr (w_tap_addr[t]),
            .o_rdata (w_tap_texel[t])
        );
    end

    tsw_blend u_blend (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_tap_oob   (w_tap_oob),
        .i_tap_wt    (w_tap_wt),
        .i_tap_texel (w_tap_texel),
        .o_chan      (w_chan)
    );

    assign o_stall     = !w_en.s1;
    assign o_valid     = r_v6;
    assign o_red_out   = w_chan[0];
    assign o_green_out = w_chan[1];
    assign o_blue_out  = w_chan[2];

endmodule

// ===== rtl/tsw_checker.sv =====
module tsw_checker import tsw_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             i_cmd,
    input logic             o_valid,
    input logic             i_stall,
    input logic [OUT_W-1:0] o_red_out,
    input logic [OUT_W-1:0] o_green_out,
    input logic [OUT_W-1:0] o_blue_out
);

    logic [3:0] r_pending;
    logic [3:0] n_pending;

    // Count sample items accepted but not yet delivered
    always_comb begin
        n_pending = r_pending;
        if (i_valid && !o_stall && (t_cmd'(i_cmd) == CMD_SAMPLE)) begin
            n_pending = n_pending + 4'd1;
        end
        if (o_valid && !i_stall) begin
            n_pending = n_pending - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_red_out) && $stable(o_green_out)
            && $stable(o_blue_out))
        else $error("stalled result changed or vanished");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pending != 4'd0)
        else $error("result without a pending sample item");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 4'(PIPE_STAGES))
        else $error("more sample items in flight than pipeline stages");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_red_out <= CHAN_ONE && o_green_out <= CHAN_ONE
            && o_blue_out <= CHAN_ONE)
        else $error("result channel above 1.0");

endmodule

bind texture_sampler_wrap_bilinear_unit tsw_checker u_tsw_checker (.*);
